// ===== src/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// shared constants for the sphere versus box classifier: default coordinate
// width, apb widths, register indexes and relation codes
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

	// default coordinate width, signed q16.8
	localparam int COORD_WIDTH_DEF = 24;

	// apb side
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_MIN_X = 3'd0;
	localparam reg_idx_t REG_MIN_Y = 3'd1;
	localparam reg_idx_t REG_MIN_Z = 3'd2;
	localparam reg_idx_t REG_MAX_X = 3'd3;
	localparam reg_idx_t REG_MAX_Y = 3'd4;
	localparam reg_idx_t REG_MAX_Z = 3'd5;

	typedef logic [1:0] relation_t;

	localparam relation_t REL_OUTSIDE    = 2'd0;
	localparam relation_t REL_INTERSECTS = 2'd1;
	localparam relation_t REL_INSIDE     = 2'd2;

endpackage

`default_nettype wire

// ===== src/sbc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sbc_cfg_regs
// apb register file holding the box corners
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_cfg_regs #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [sbc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [sbc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [sbc_pkg::APB_DATA_W-1:0]    prdata,
	output logic      [2:0][COORD_WIDTH-1:0]       box_lo,
	output logic      [2:0][COORD_WIDTH-1:0]       box_hi
);
	import sbc_pkg::*;

	localparam logic [COORD_WIDTH-1:0] MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	reg_idx_t                       idx;
	logic                           wr_en;
	logic     [COORD_WIDTH-1:0]     wdata;
	logic     [2:0][COORD_WIDTH-1:0] lo_q;
	logic     [2:0][COORD_WIDTH-1:0] hi_q;

	assign idx   = paddr[APB_ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign wdata = pwdata[COORD_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= {3{MAX_POS}};
			hi_q <= {3{MIN_NEG}};
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_X: lo_q[0] <= wdata;
				REG_MIN_Y: lo_q[1] <= wdata;
				REG_MIN_Z: lo_q[2] <= wdata;
				REG_MAX_X: hi_q[0] <= wdata;
				REG_MAX_Y: hi_q[1] <= wdata;
				REG_MAX_Z: hi_q[2] <= wdata;
				default: ;
			endcase
		end
	end

	// reads return the sign-extended corner
	always_comb begin
		unique case (idx)
			REG_MIN_X: prdata = APB_DATA_W'($signed(lo_q[0]));
			REG_MIN_Y: prdata = APB_DATA_W'($signed(lo_q[1]));
			REG_MIN_Z: prdata = APB_DATA_W'($signed(lo_q[2]));
			REG_MAX_X: prdata = APB_DATA_W'($signed(hi_q[0]));
			REG_MAX_Y: prdata = APB_DATA_W'($signed(hi_q[1]));
			REG_MAX_Z: prdata = APB_DATA_W'($signed(hi_q[2]));
			default:   prdata = '0;
		endcase
	end

	assign box_lo = lo_q;
	assign box_hi = hi_q;

endmodule

`default_nettype wire

// ===== src/sbc_axis.sv =====
// ----------------------------------------------------------------------------
// sbc_axis
// one axis of the test: distance from the centre to the nearer face when the
// centre lies outside the slab, and whether the sphere extent crosses a face
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_axis #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic [COORD_WIDTH-1:0] center,
	input  wire logic [COORD_WIDTH-1:0] lo,
	input  wire logic [COORD_WIDTH-1:0] hi,
	input  wire logic [COORD_WIDTH-2:0] radius,
	output logic      [COORD_WIDTH-1:0] gap,
	output logic                        cut
);
	import sbc_pkg::*;

	localparam int XW = COORD_WIDTH + 2;

	logic signed [XW-1:0] c_x;
	logic signed [XW-1:0] lo_x;
	logic signed [XW-1:0] hi_x;
	logic signed [XW-1:0] r_x;
	logic signed [XW-1:0] below;
	logic signed [XW-1:0] above;

	assign c_x  = XW'($signed(center));
	assign lo_x = XW'($signed(lo));
	assign hi_x = XW'($signed(hi));
	assign r_x  = $signed(XW'(radius));

	assign below = lo_x - c_x;
	assign above = c_x - hi_x;

	// below-min wins over above-max for an inverted box
	always_comb begin
		if (c_x < lo_x) begin
			gap = below[COORD_WIDTH-1:0];
		end else if (c_x > hi_x) begin
			gap = above[COORD_WIDTH-1:0];
		end else begin
			gap = '0;
		end
	end

	assign cut = ((c_x - r_x) < lo_x) || ((c_x + r_x) > hi_x);

endmodule

`default_nettype wire

// ===== src/sphere_box_classify.sv =====
// ----------------------------------------------------------------------------
// sphere_box_classify
// classifies a sphere against an axis-aligned box held in apb registers
// ----------------------------------------------------------------------------
// usage
//   the box corners are written over the apb port (min x/y/z at 0x00..0x08,
//   max x/y/z at 0x0c..0x14); the user must do so only while no sphere is
//   in flight, as the block itself does not enforce it. a sphere (centre
//   q16.8 signed, radius q15.8 unsigned) is a transfer on the item channel;
//   each one gives exactly one relation transfer on the result channel:
//   0 outside, 1 crosses the box boundary, 2 fully inside. an item passes
//   four register stages before its result_valid rises. the pipeline takes
//   one sphere per cycle while result_ready holds: stage 1 per-axis face
//   distances and extent checks, stage 2 the squaring multipliers, stage 3
//   the sum of squares, stage 4 the compare against radius squared, the
//   output register. each stage holds only while its successor is full and
//   stalled, so a stalled receiver fills the bubbles first and then holds
//   item_ready low; nothing is dropped or repeated. reset empties the
//   pipeline and sets the box to an inverted, empty box (min at the largest
//   value, max at the smallest).
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_box_classify #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [sbc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [sbc_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [sbc_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic [COORD_WIDTH-1:0]         sphere_x,
	input  wire logic [COORD_WIDTH-1:0]         sphere_y,
	input  wire logic [COORD_WIDTH-1:0]         sphere_z,
	input  wire logic [COORD_WIDTH-2:0]         sphere_radius,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic      [1:0]                     relation
);
	import sbc_pkg::*;

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int RSQ_W = 2 * COORD_WIDTH - 2;
	localparam int SUM_W = 2 * COORD_WIDTH + 2;

	logic [2:0][COORD_WIDTH-1:0] box_lo;
	logic [2:0][COORD_WIDTH-1:0] box_hi;
	logic [2:0][COORD_WIDTH-1:0] center;
	logic [2:0][COORD_WIDTH-1:0] gap;
	logic [2:0]                  cut;

	logic en1;
	logic en2;
	logic en3;
	logic en4;

	logic                        vld_s1;
	logic [2:0][COORD_WIDTH-1:0] gap_s1;
	logic                        cut_s1;
	logic [COORD_WIDTH-2:0]      rad_s1;

	logic                        vld_s2;
	logic [2:0][SQ_W-1:0]        sq_s2;
	logic [RSQ_W-1:0]            rsq_s2;
	logic                        cut_s2;

	logic                        vld_s3;
	logic [SUM_W-1:0]            sum_s3;
	logic [RSQ_W-1:0]            rsq_s3;
	logic                        cut_s3;

	logic                        vld_s4;
	relation_t                   rel_s4;

	sbc_cfg_regs #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.box_lo (box_lo),
		.box_hi (box_hi)
	);

	assign pready = 1'b1;

	assign center[0] = sphere_x;
	assign center[1] = sphere_y;
	assign center[2] = sphere_z;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		sbc_axis #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_axis (
			.center(center[a]),
			.lo    (box_lo[a]),
			.hi    (box_hi[a]),
			.radius(sphere_radius),
			.gap   (gap[a]),
			.cut   (cut[a])
		);
	end

	// a stage moves when it is empty or its successor moves
	assign en4        = !vld_s4 || result_ready;
	assign en3        = !vld_s3 || en4;
	assign en2        = !vld_s2 || en3;
	assign en1        = !vld_s1 || en2;
	assign item_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= item_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			gap_s1 <= gap;
			cut_s1 <= |cut;
			rad_s1 <= sphere_radius;
		end
		if (en2) begin
			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= SQ_W'(gap_s1[a]) * SQ_W'(gap_s1[a]);
			end
			rsq_s2 <= RSQ_W'(rad_s1) * RSQ_W'(rad_s1);
			cut_s2 <= cut_s1;
		end
		if (en3) begin
			// wide enough that the sum never wraps
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
			rsq_s3 <= rsq_s2;
			cut_s3 <= cut_s2;
		end
		if (en4) begin
			if (sum_s3 >= SUM_W'(rsq_s3)) begin
				rel_s4 <= REL_OUTSIDE;
			end else if (cut_s3) begin
				rel_s4 <= REL_INTERSECTS;
			end else begin
				rel_s4 <= REL_INSIDE;
			end
		end
	end

	assign result_valid = vld_s4;
	assign relation     = rel_s4;

endmodule

`default_nettype wire
